// ----- design/rxsa_pkg.sv -----
`default_nettype none

package rxsa_pkg;

    // Number of slot ids managed by default
    localparam int ID_COUNT_DEF = 256;

    // Field widths of an item
    localparam int ID_W     = 8;
    localparam int STATUS_W = 16;
    localparam int OFFSET_W = 16;
    localparam int FLAGS_W  = 16;
    localparam int LEN_W    = 15;
    localparam int OCTET_W  = 24;
    localparam int FRAGS_W  = 9;
    localparam int CODE_W   = 2;

    // Response flag bits
    localparam int FLAG_MORE_BIT   = 2;
    localparam int FLAG_PREFIX_BIT = 4;

    // Function selector
    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_RESP  = 1'b1;

    // Result codes
    localparam logic [CODE_W-1:0] RC_OK       = 2'd0;
    localparam logic [CODE_W-1:0] RC_NO_ID    = 2'd1;
    localparam logic [CODE_W-1:0] RC_NOT_BUSY = 2'd2;

    localparam logic [OCTET_W-1:0] OCTET_MAX = {OCTET_W{1'b1}};
    localparam logic [FRAGS_W-1:0] FRAG_MAX  = {FRAGS_W{1'b1}};

    // Commands from the controller to the datapath
    typedef struct packed {
        logic clr_wr;   // write one entry of the link memory initialisation
        logic accept;   // an input item is taken this cycle
        logic exec;     // memory data of the held item is valid, finish it
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic clr_last; // the initialisation pass writes its final entry
    } t_status;

    // One result item
    typedef struct packed {
        logic [ID_W-1:0]     alloc_id;
        logic [CODE_W-1:0]   result_code;
        logic                frag_used;
        logic [OFFSET_W-1:0] frag_offset;
        logic [LEN_W-1:0]    frag_length;
        logic                packet_done;
        logic [OCTET_W-1:0]  total_octets;
        logic [FRAGS_W-1:0]  total_frags;
        logic [FLAGS_W-1:0]  packet_flags;
        logic                packet_failed;
        logic [OFFSET_W-1:0] gso_size;
        logic                gso_present;
    } t_result;

endpackage

`default_nettype wire

// ----- design/rxsa_ram.sv -----
`default_nettype none

// Simple dual-port RAM, one write and one registered read port.
module rxsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ----- design/rxsa_ctrl.sv -----
`default_nettype none

// Sequencer: initialisation pass, then one item at a time (accept, execute).
module rxsa_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic              i_out_ready,
    input  wire rxsa_pkg::t_status i_status,
    output logic                   o_in_ready,
    output logic                   o_out_valid,
    output rxsa_pkg::t_cmd         o_cmd
);
    import rxsa_pkg::*;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_EXEC  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_status.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                // The result register must be empty, or emptied this cycle.
                o_in_ready   = !r_out_valid || i_out_ready;
                o_cmd.accept = o_in_ready && i_in_valid;
                if (o_cmd.accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = ST_IDLE;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.exec) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// ----- design/rxsa_dp.sv -----
`default_nettype none

// Datapath: free list head, link and busy memory, packet assembly totals.
module rxsa_dp #(
    parameter int ID_COUNT = rxsa_pkg::ID_COUNT_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire rxsa_pkg::t_cmd                    i_cmd,
    input  wire logic                              i_func,
    input  wire logic [rxsa_pkg::ID_W-1:0]         i_resp_id,
    input  wire logic [rxsa_pkg::STATUS_W-1:0]     i_resp_status,
    input  wire logic [rxsa_pkg::OFFSET_W-1:0]     i_resp_offset,
    input  wire logic [rxsa_pkg::FLAGS_W-1:0]      i_resp_flags,
    output rxsa_pkg::t_status                      o_status,
    output rxsa_pkg::t_result                      o_result
);
    import rxsa_pkg::*;

    localparam int IDW = $clog2(ID_COUNT);
    // Memory word: busy bit, no-link mark, link
    localparam int EW       = IDW + 2;
    localparam int BUSY_BIT = EW - 1;
    localparam int NOLK_BIT = EW - 2;

    // Held input item
    logic                r_func;
    logic [ID_W-1:0]     r_id;
    logic [STATUS_W-1:0] r_st;
    logic [OFFSET_W-1:0] r_off;
    logic [FLAGS_W-1:0]  r_fl;

    // Free list
    logic [IDW-1:0] r_head;
    logic [IDW-1:0] n_head;
    logic           r_head_valid;
    logic           n_head_valid;
    logic [IDW-1:0] r_clr;

    // Assembly state
    logic [OCTET_W-1:0]  r_oct;
    logic [OCTET_W-1:0]  n_oct;
    logic [FRAGS_W-1:0]  r_frags;
    logic [FRAGS_W-1:0]  n_frags;
    logic [FLAGS_W-1:0]  r_flags;
    logic [FLAGS_W-1:0]  n_flags;
    logic                r_err;
    logic                n_err;
    logic [OFFSET_W-1:0] r_seg;
    logic [OFFSET_W-1:0] n_seg;
    logic                r_seg_seen;
    logic                n_seg_seen;

    t_result r_res;
    t_result n_res;

    // Memory signals
    logic           mem_we;
    logic [IDW-1:0] mem_waddr;
    logic [EW-1:0]  mem_wdata;
    logic [IDW-1:0] mem_raddr;
    logic [EW-1:0]  mem_rdata;

    logic                id_in_range;
    logic [IDW-1:0]      id_idx;
    logic                neg;
    logic [LEN_W-1:0]    len;
    logic                is_data;
    logic                done;
    logic [OCTET_W:0]    oct_sum;

    assign id_idx      = IDW'(r_id);
    assign id_in_range = 32'(r_id) < 32'(ID_COUNT);

    // Allocation reads the head entry, a response reads the entry it names.
    assign mem_raddr = (i_func == FUNC_RESP) ? IDW'(i_resp_id) : r_head;

    assign o_status.clr_last = (r_clr == IDW'(ID_COUNT - 1));

    rxsa_ram #(
        .WIDTH (EW),
        .DEPTH (ID_COUNT)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (i_cmd.accept),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign neg     = r_st[STATUS_W-1];
    assign len     = neg ? '0 : r_st[LEN_W-1:0];
    assign is_data = !r_fl[FLAG_PREFIX_BIT];
    assign done    = !r_fl[FLAG_MORE_BIT];
    assign oct_sum = {1'b0, r_oct} + (OCTET_W+1)'(len);

    always_comb begin
        n_head       = r_head;
        n_head_valid = r_head_valid;
        n_res        = r_res;
        n_oct        = r_oct;
        n_frags      = r_frags;
        n_flags      = r_flags;
        n_err        = r_err;
        n_seg        = r_seg;
        n_seg_seen   = r_seg_seen;
        mem_we       = 1'b0;
        mem_waddr    = r_clr;
        mem_wdata    = '0;

        if (i_cmd.clr_wr) begin
            // Entry i links to i-1, entry 0 ends the list.
            mem_we              = 1'b1;
            mem_wdata[IDW-1:0]  = r_clr - IDW'(1);
            mem_wdata[NOLK_BIT] = (r_clr == '0);
        end

        if (i_cmd.exec) begin
            n_res = '0;
            if (r_func == FUNC_ALLOC) begin
                if (r_head_valid) begin
                    n_res.alloc_id    = ID_W'(r_head);
                    n_res.result_code = RC_OK;
                    mem_we              = 1'b1;
                    mem_waddr           = r_head;
                    mem_wdata[BUSY_BIT] = 1'b1;
                    mem_wdata[NOLK_BIT] = 1'b1;
                    n_head              = mem_rdata[IDW-1:0];
                    n_head_valid        = !mem_rdata[NOLK_BIT];
                end else begin
                    n_res.result_code = RC_NO_ID;
                end
            end else begin
                if (id_in_range && mem_rdata[BUSY_BIT]) begin
                    n_res.result_code   = RC_OK;
                    mem_we              = 1'b1;
                    mem_waddr           = id_idx;
                    mem_wdata[IDW-1:0]  = r_head;
                    mem_wdata[NOLK_BIT] = !r_head_valid;
                    n_head              = id_idx;
                    n_head_valid        = 1'b1;
                end else begin
                    n_res.result_code = RC_NOT_BUSY;
                end

                n_flags = r_flags | r_fl;
                n_err   = r_err | neg;
                if (is_data) begin
                    n_oct   = oct_sum[OCTET_W] ? OCTET_MAX : oct_sum[OCTET_W-1:0];
                    n_frags = (r_frags == FRAG_MAX) ? r_frags : r_frags + FRAGS_W'(1);
                end else begin
                    n_seg      = r_off;
                    n_seg_seen = 1'b1;
                end

                n_res.frag_used     = is_data;
                n_res.frag_offset   = is_data ? r_off : '0;
                n_res.frag_length   = is_data ? len : '0;
                n_res.packet_done   = done;
                n_res.total_octets  = n_oct;
                n_res.total_frags   = n_frags;
                n_res.packet_flags  = n_flags;
                n_res.packet_failed = n_err;
                n_res.gso_size      = n_seg;
                n_res.gso_present   = n_seg_seen;

                if (done) begin
                    n_oct      = '0;
                    n_frags    = '0;
                    n_flags    = '0;
                    n_err      = 1'b0;
                    n_seg      = '0;
                    n_seg_seen = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_func <= i_func;
            r_id   <= i_resp_id;
            r_st   <= i_resp_status;
            r_off  <= i_resp_offset;
            r_fl   <= i_resp_flags;
        end
        r_res <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head       <= IDW'(ID_COUNT - 1);
            r_head_valid <= 1'b1;
            r_clr        <= '0;
            r_oct        <= '0;
            r_frags      <= '0;
            r_flags      <= '0;
            r_err        <= 1'b0;
            r_seg        <= '0;
            r_seg_seen   <= 1'b0;
        end else begin
            r_head       <= n_head;
            r_head_valid <= n_head_valid;
            if (i_cmd.clr_wr) begin
                r_clr <= r_clr + IDW'(1);
            end
            r_oct      <= n_oct;
            r_frags    <= n_frags;
            r_flags    <= n_flags;
            r_err      <= n_err;
            r_seg      <= n_seg;
            r_seg_seen <= n_seg_seen;
        end
    end

    assign o_result = r_res;

endmodule

`default_nettype wire

// ----- design/rx_slot_allocator_and_chain_assembler_unit.sv -----
// Receive-slot allocator and fragment chain assembler.
// Input channel s_axis_*: tuser selects the function (0 allocate a slot id,
// 1 consume one receive response); tdata carries the response fields.
// Output channel m_axis_*: exactly one result item per input item, in order.
// tlast marks the response that ends a packet; tuser carries the result code
// and the data-fragment marker; tdata carries the id and the packet totals.
// Each item first reads the link memory (a synchronous single-read RAM
// holding the free list links and busy bits), then updates the list head,
// writes the memory back and loads the result register. A new item is not
// accepted until the previous one has been finished.
// After reset the link memory is initialised, one entry per cycle; no item
// is accepted during that time.
// When the receiver stalls the result waits in its register and the block
// stops taking input until that item has been taken; a new item can be
// accepted in the same cycle as the waiting result leaves.
`default_nettype none

module rx_slot_allocator_and_chain_assembler_unit #(
    parameter int ID_COUNT = rxsa_pkg::ID_COUNT_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // resp_id[7:0], resp_status[23:8], resp_offset[39:24], resp_flags[55:40]
    input  wire logic [55:0]  s_axis_tdata,
    // func[0]
    input  wire logic [0:0]   s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // alloc_id[7:0], frag_offset[23:8], frag_length[38:24],
    // total_octets[62:39], total_frags[71:63], packet_flags[87:72],
    // packet_failed[88], gso_size[104:89], gso_present[105], zero[111:106]
    output logic [111:0]      m_axis_tdata,
    // result_code[1:0], frag_used[2]
    output logic [2:0]        m_axis_tuser,
    // packet_done
    output logic              m_axis_tlast
);
    import rxsa_pkg::*;

    t_cmd    cmd;
    t_status status;
    t_result res;

    rxsa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_status    (status),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_cmd       (cmd)
    );

    rxsa_dp #(
        .ID_COUNT (ID_COUNT)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_func        (s_axis_tuser[0]),
        .i_resp_id     (s_axis_tdata[7:0]),
        .i_resp_status (s_axis_tdata[23:8]),
        .i_resp_offset (s_axis_tdata[39:24]),
        .i_resp_flags  (s_axis_tdata[55:40]),
        .o_status      (status),
        .o_result      (res)
    );

    // Pack the result item onto the output channel.
    assign m_axis_tdata = {
        6'd0,
        res.gso_present,
        res.gso_size,
        res.packet_failed,
        res.packet_flags,
        res.total_frags,
        res.total_octets,
        res.frag_length,
        res.frag_offset,
        res.alloc_id
    };
    assign m_axis_tuser = {res.frag_used, res.result_code};
    assign m_axis_tlast = res.packet_done;

    // No item may be taken while the link memory is being initialised.
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.clr_wr |-> !s_axis_tready)
        else $error("input ready during link memory initialisation");

    // An accepted item is finished in the following cycle.
    a_accept_then_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> cmd.exec)
        else $error("accepted item not executed in the next cycle");

    // Finishing an item always presents a result.
    a_exec_then_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.exec |=> (m_axis_tvalid && !s_axis_tready || m_axis_tvalid))
        else $error("executed item produced no result");

    // Result codes stay within the defined set.
    a_code_defined: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser[1:0] == RC_OK || m_axis_tuser[1:0] == RC_NO_ID ||
                           m_axis_tuser[1:0] == RC_NOT_BUSY))
        else $error("undefined result code");

endmodule

`default_nettype wire
